>>> hw/rtl/xcfp_pkg.sv
// Package for the XOR-checked frame parser: beat classes, queue entry and
// result types, and the fixed frame constants. No dependencies.
package xcfp_pkg;

  localparam logic [7:0]  SOF_BYTE    = 8'hFE;
  localparam logic [15:0] CMD_PWM_RSP = 16'h8144;
  localparam logic [15:0] CLUSTER_PWM = 16'h8003;
  localparam logic [15:0] ADDR_ANY    = 16'hFFFF;
  localparam logic [39:0] IEEE_UPPER  = 40'h00124B0001;
  localparam logic [23:0] IEEE_RESET  = 24'h33B481;

  // Class of one byte as seen by the front end
  typedef enum logic [2:0] {
    OP_SOF  = 3'd0,
    OP_LEN  = 3'd1,
    OP_CMD0 = 3'd2,
    OP_CMD1 = 3'd3,
    OP_DATA = 3'd4,
    OP_FCS  = 3'd5
  } xcfp_op_e;

  typedef struct packed {
    xcfp_op_e   op;
    logic [7:0] pos;
    logic [7:0] data;
  } xcfp_entry_t;

  typedef struct packed {
    logic        frame_ok;
    logic        report_match;
    logic [15:0] command_word;
    logic [15:0] cluster_id;
    logic [15:0] source_address;
    logic [63:0] ieee_address;
    logic [15:0] short_address;
    logic [15:0] pwm_value;
    logic [7:0]  payload_length;
  } xcfp_result_t;

endpackage

>>> hw/rtl/xcfp_front.sv
// Front end of the frame parser: hunts for the start byte, tracks the frame
// position and pushes classified beats into the queue. Uses xcfp_pkg.
module xcfp_front import xcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  output xcfp_entry_t push_entry_o,
  output logic        push_valid_o,
  input  logic        push_ready_i
);

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_CMD0 = 6'b000100,
    PH_CMD1 = 6'b001000,
    PH_DATA = 6'b010000,
    PH_FCS  = 6'b100000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] cnt_inc;
  logic       acc;

  assign rx_ready_o = push_ready_i;
  assign acc        = rx_valid_i && push_ready_i;
  assign cnt_inc    = cnt_q + 8'd1;

  always_comb begin
    phase_d           = phase_q;
    len_d             = len_q;
    cnt_d             = cnt_q;
    push_entry_o.op   = OP_SOF;
    push_entry_o.pos  = cnt_q;
    push_entry_o.data = rx_byte_i;
    push_valid_o      = 1'b0;
    unique case (phase_q)
      PH_HUNT: begin
        // drop anything but the start byte
        if (rx_byte_i == SOF_BYTE) begin
          push_valid_o = acc;
          phase_d      = PH_LEN;
        end
      end
      PH_LEN: begin
        push_entry_o.op = OP_LEN;
        push_valid_o    = acc;
        len_d           = rx_byte_i;
        cnt_d           = 8'd0;
        phase_d         = PH_CMD0;
      end
      PH_CMD0: begin
        push_entry_o.op = OP_CMD0;
        push_valid_o    = acc;
        phase_d         = PH_CMD1;
      end
      PH_CMD1: begin
        push_entry_o.op = OP_CMD1;
        push_valid_o    = acc;
        phase_d         = (len_q != 8'd0) ? PH_DATA : PH_FCS;
      end
      PH_DATA: begin
        push_entry_o.op = OP_DATA;
        push_valid_o    = acc;
        cnt_d           = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PH_FCS;
        end
      end
      PH_FCS: begin
        push_entry_o.op = OP_FCS;
        push_valid_o    = acc;
        phase_d         = PH_HUNT;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
    end else if (acc) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/xcfp_fifo.sv
// Short queue of classified beats between front and back end.
// Uses xcfp_pkg for the entry type.
module xcfp_fifo import xcfp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  xcfp_entry_t push_entry_i,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  output xcfp_entry_t pop_entry_o,
  output logic        pop_valid_o,
  input  logic        pop_ready_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  xcfp_entry_t           slot_q [DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q;
  logic                  do_push, do_pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/xcfp_back.sv
// Back end of the frame parser: running XOR, field captures, check and
// report decision, and the output register. Uses xcfp_pkg.
module xcfp_back import xcfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [15:0]  target_address_i,
  input  xcfp_entry_t  pop_entry_i,
  input  logic         pop_valid_i,
  output logic         pop_ready_o,
  output xcfp_result_t result_o,
  output logic         result_valid_o,
  input  logic         result_ready_i
);

  localparam logic [7:0] PosClusterLo = 8'd2;
  localparam logic [7:0] PosClusterHi = 8'd3;
  localparam logic [7:0] PosSourceLo  = 8'd4;
  localparam logic [7:0] PosSourceHi  = 8'd5;
  localparam logic [7:0] PosIeee0     = 8'd17;
  localparam logic [7:0] PosIeee1     = 8'd18;
  localparam logic [7:0] PosIeee2     = 8'd19;
  localparam logic [7:0] PosShortLo   = 8'd22;
  localparam logic [7:0] PosShortHi   = 8'd23;
  localparam logic [7:0] PosPwmLo     = 8'd24;
  localparam logic [7:0] PosPwmHi     = 8'd25;

  logic [7:0]   len_q, len_d;
  logic [7:0]   xor_q, xor_d;
  logic [15:0]  cmd_q, cmd_d;
  logic [63:0]  fields_q, fields_d;
  logic [23:0]  cap_ieee_q, cap_ieee_d;
  logic [23:0]  held_q, held_d;
  logic         out_valid_q;
  xcfp_result_t out_q;
  xcfp_result_t res;
  logic         is_fcs, do_pop, ok;
  logic [7:0]   b;

  assign b      = pop_entry_i.data;
  assign is_fcs = (pop_entry_i.op == OP_FCS);
  // hold a check byte until the output register is free
  assign pop_ready_o = !is_fcs || !out_valid_q || result_ready_i;
  assign do_pop      = pop_valid_i && pop_ready_o;
  assign ok          = (b == xor_q);

  always_comb begin
    len_d      = len_q;
    xor_d      = xor_q;
    cmd_d      = cmd_q;
    fields_d   = fields_q;
    cap_ieee_d = cap_ieee_q;
    held_d     = held_q;
    unique case (pop_entry_i.op)
      OP_SOF: begin
        fields_d   = '0;
        cap_ieee_d = '0;
      end
      OP_LEN: begin
        len_d = b;
        xor_d = b;
      end
      OP_CMD0: begin
        cmd_d = {8'd0, b};
        xor_d = xor_q ^ b;
      end
      OP_CMD1: begin
        cmd_d = {b, cmd_q[7:0]};
        xor_d = xor_q ^ b;
      end
      OP_DATA: begin
        xor_d = xor_q ^ b;
        case (pop_entry_i.pos)
          PosClusterLo: fields_d[7:0]     = b;
          PosClusterHi: fields_d[15:8]    = b;
          PosSourceLo:  fields_d[23:16]   = b;
          PosSourceHi:  fields_d[31:24]   = b;
          PosShortLo:   fields_d[39:32]   = b;
          PosShortHi:   fields_d[47:40]   = b;
          PosPwmLo:     fields_d[55:48]   = b;
          PosPwmHi:     fields_d[63:56]   = b;
          PosIeee0:     cap_ieee_d[7:0]   = b;
          PosIeee1:     cap_ieee_d[15:8]  = b;
          PosIeee2:     cap_ieee_d[23:16] = b;
          default: ;
        endcase
      end
      OP_FCS: begin
        if (ok && cmd_q == CMD_PWM_RSP) begin
          held_d = cap_ieee_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.frame_ok       = ok;
    res.report_match   = ok && (cmd_q == CMD_PWM_RSP) && (fields_q[15:0] == CLUSTER_PWM) &&
                         ((target_address_i == ADDR_ANY) ||
                          (fields_q[31:16] == target_address_i));
    res.command_word   = cmd_q;
    res.cluster_id     = fields_q[15:0];
    res.source_address = fields_q[31:16];
    res.ieee_address   = {IEEE_UPPER, held_d};
    res.short_address  = fields_q[47:32];
    res.pwm_value      = fields_q[63:48];
    res.payload_length = len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= 8'd0;
      xor_q       <= 8'd0;
      cmd_q       <= 16'd0;
      fields_q    <= 64'd0;
      cap_ieee_q  <= IEEE_RESET;
      held_q      <= IEEE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (do_pop) begin
        len_q      <= len_d;
        xor_q      <= xor_d;
        cmd_q      <= cmd_d;
        fields_q   <= fields_d;
        cap_ieee_q <= cap_ieee_d;
        held_q     <= held_d;
      end
      if (do_pop && is_fcs) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop && is_fcs) begin
      out_q <= res;
    end
  end

  assign result_o       = out_q;
  assign result_valid_o = out_valid_q;

endmodule

>>> hw/rtl/xor_checked_frame_parser.sv
// Top level of the XOR-checked frame parser: APB register, front end, beat
// queue and back end. Depends on xcfp_pkg, xcfp_front, xcfp_fifo, xcfp_back.
//
// Usage:
//   Feed received serial bytes on rx_byte_i with rx_valid_i/rx_ready_o, one
//   beat per byte. Frames are 0xFE, length L, two command bytes, L data
//   bytes and an XOR check byte over length, command and data. Each check
//   byte yields one result beat on the out_* channel (out_valid_o and
//   out_ready_i) carrying the check flag, report flag and captured fields.
//   Bytes outside a frame yield nothing.
//   Throughput: one byte per cycle, set by the front end's position
//   tracking; the back end keeps pace as long as results are taken.
//   Result path: an accepted check byte is written into the queue, then
//   popped from it into the output register, where its result is valid.
//   Stall: while the output register is full and out_ready_i is low, the
//   back end holds the next check byte; earlier bytes drain, and the queue
//   (FIFO_DEPTH beats) absorbs input before rx_ready_o drops.
//   Reset: hunting for the start byte, queue empty, no result pending, target
//   address zero, IEEE low bits at their default.
//   Write target_address at APB byte address 0 only while the block is idle.
module xor_checked_frame_parser import xcfp_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_ok_o,
  output logic        report_match_o,
  output logic [15:0] command_word_o,
  output logic [15:0] cluster_id_o,
  output logic [15:0] source_address_o,
  output logic [63:0] ieee_address_o,
  output logic [15:0] short_address_o,
  output logic [15:0] pwm_value_o,
  output logic [7:0]  payload_length_o
);

  localparam logic REG_TARGET = 1'b0;

  logic [15:0]  target_q;
  logic         reg_sel;
  xcfp_entry_t  push_entry, pop_entry;
  logic         push_valid, push_ready, pop_valid, pop_ready;
  xcfp_result_t result;

  // register index sits above the byte offset
  assign reg_sel = (paddr[2] == REG_TARGET);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {16'd0, target_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 16'd0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      target_q <= pwdata[15:0];
    end
  end

  // classify beats and track the frame position
  xcfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .push_entry_o (push_entry),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // decouple front and back so each can stall on its own
  xcfp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_entry_i (push_entry),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_entry_o  (pop_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  // capture fields, check the frame and register the result
  xcfp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .target_address_i (target_q),
    .pop_entry_i      (pop_entry),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .result_o         (result),
    .result_valid_o   (out_valid_o),
    .result_ready_i   (out_ready_i)
  );

  assign frame_ok_o       = result.frame_ok;
  assign report_match_o   = result.report_match;
  assign command_word_o   = result.command_word;
  assign cluster_id_o     = result.cluster_id;
  assign source_address_o = result.source_address;
  assign ieee_address_o   = result.ieee_address;
  assign short_address_o  = result.short_address;
  assign pwm_value_o      = result.pwm_value;
  assign payload_length_o = result.payload_length;

endmodule
